@@ sv/safs_pkg.sv @@
// ----------------------------------------------------------------------------
// safs_pkg
// Shared types, widths and codes of the SPI converter frame sequencer.
// ----------------------------------------------------------------------------
package safs_pkg;

  // Default chain and ring geometry
  localparam int DEF_ADC_COUNT     = 2;
  localparam int DEF_CHANNEL_COUNT = 8;
  localparam int DEF_RING_SLOTS    = 4;

  // Fixed field widths
  localparam int KIND_W    = 3;
  localparam int OKIND_W   = 2;
  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 24;
  localparam int CH_W      = 4;
  localparam int CH_CNT_W  = 5;
  localparam int SLOT_W    = 4;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IDX_W     = 6;
  localparam int QUEUE_DEPTH = 4;

  // Input event kinds
  localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BURST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RX      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDGE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

  // Result kinds
  localparam logic [OKIND_W-1:0] OUT_TX     = 2'd0;
  localparam logic [OKIND_W-1:0] OUT_SAMPLE = 2'd1;
  localparam logic [OKIND_W-1:0] OUT_FRAME  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CONF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OTHER_CONF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGES      = 2'd3;

  // SPI command bytes
  localparam logic [BYTE_W-1:0] CMD_WR_CONF    = 8'h60;
  localparam logic [BYTE_W-1:0] CMD_WR_INSTANT = 8'h40;
  localparam logic [BYTE_W-1:0] ADC_RESET_BYTE = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_WR_RATE    = 8'h50;
  localparam logic [BYTE_W-1:0] CMD_RD_DATA    = 8'hF0;

  localparam int INSTANT_BYTES_PER_ADC = 4;
  localparam int DATA_BYTES_PER_ADC    = 12;
  localparam int STREAM_FILLER         = 6;

  // Job codes handed from the front end to the back end
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] JOB_START   = 3'd0;
  localparam logic [JOB_W-1:0] JOB_CONF    = 3'd1;
  localparam logic [JOB_W-1:0] JOB_INSTANT = 3'd2;
  localparam logic [JOB_W-1:0] JOB_RATE    = 3'd3;
  localparam logic [JOB_W-1:0] JOB_DATA    = 3'd4;
  localparam logic [JOB_W-1:0] JOB_STREAM  = 3'd5;
  localparam logic [JOB_W-1:0] JOB_SAMPLE  = 3'd6;
  localparam logic [JOB_W-1:0] JOB_FRAME   = 3'd7;

  typedef struct packed {
    logic [JOB_W-1:0]    code;
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     channel;
    logic [SLOT_W-1:0]   slot;
    logic                ovf;
    logic                sel;
  } job_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_conf;
    logic [BYTE_W-1:0] other_conf;
    logic [RATE_W-1:0] rate_word;
  } cfg_t;

  // Number of results a job expands into
  function automatic logic [IDX_W-1:0] job_len(input logic [JOB_W-1:0] code,
                                               input int adc);
    int n;
    begin
      case (code)
        JOB_START:   n = 1 + adc;
        JOB_CONF:    n = 1 + adc;
        JOB_INSTANT: n = 1 + INSTANT_BYTES_PER_ADC * adc;
        JOB_RATE:    n = 3;
        JOB_DATA:    n = 1 + DATA_BYTES_PER_ADC * adc;
        JOB_STREAM:  n = 1 + STREAM_FILLER;
        JOB_SAMPLE:  n = 1;
        JOB_FRAME:   n = 2;
        default:     n = 1;
      endcase
      job_len = IDX_W'(n);
    end
  endfunction

endpackage

@@ sv/safs_queue.sv @@
// ----------------------------------------------------------------------------
// safs_queue
// Small first-in first-out job queue in flops, head visible on the output.
// ----------------------------------------------------------------------------
module safs_queue import safs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store entry at the tail
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL) else $error("queue fill level beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue fill level did not grow on write");

endmodule

@@ sv/safs_front.sv @@
// ----------------------------------------------------------------------------
// safs_front
// Accepts events, holds the sequencer state and configuration, and turns
// every event that causes output into one job for the back end.
// ----------------------------------------------------------------------------
module safs_front import safs_pkg::*; #(
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int RING_SLOTS    = DEF_RING_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [KIND_W-1:0]    kind,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 q_full,
  output logic                 job_valid,
  output job_t                 job,
  output cfg_t                 cfg
);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_RESET   = 3'd1;
  localparam logic [2:0] M_CONF    = 3'd2;
  localparam logic [2:0] M_INSTANT = 3'd3;
  localparam logic [2:0] M_RATE    = 3'd4;
  localparam logic [2:0] M_DATA    = 3'd5;
  localparam logic [2:0] M_STREAM  = 3'd6;

  localparam logic [CH_CNT_W-1:0] CH_TOTAL  = CH_CNT_W'(CHANNEL_COUNT);
  localparam logic [CH_CNT_W-1:0] CH_LAST   = CH_CNT_W'(CHANNEL_COUNT - 1);
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(RING_SLOTS - 1);

  logic [BYTE_W-1:0]   edges_before_stream;

  logic [2:0]          mode, mode_next;
  logic [7:0]          edge_count, edge_count_next;
  logic [CH_CNT_W-1:0] channel_count, channel_count_next;
  logic [1:0]          byte_phase, byte_phase_next;
  logic                drop_first, drop_first_next;
  logic [SAMPLE_W-1:0] assembly, assembly_next;
  logic [SLOT_W-1:0]   write_slot, write_slot_next;
  logic [SLOT_W-1:0]   read_slot, read_slot_next;
  logic                selected, selected_next;

  logic                accept;
  logic                emit;
  logic [SLOT_W-1:0]   wr_adv;
  logic [SLOT_W-1:0]   rd_adv;

  assign accept    = push && !q_full;
  assign job_valid = accept && emit;
  assign wr_adv    = (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
  assign rd_adv    = (read_slot == SLOT_LAST) ? '0 : read_slot + 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_conf      <= 8'h30;
      cfg.other_conf      <= 8'h20;
      cfg.rate_word       <= 16'h2600;
      edges_before_stream <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CONF: cfg.first_conf      <= cfg_data[BYTE_W-1:0];
        REG_OTHER_CONF: cfg.other_conf      <= cfg_data[BYTE_W-1:0];
        REG_RATE:       cfg.rate_word       <= cfg_data[RATE_W-1:0];
        REG_EDGES:      edges_before_stream <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify the event and work out the next state
  always_comb begin
    mode_next          = mode;
    edge_count_next    = edge_count;
    channel_count_next = channel_count;
    byte_phase_next    = byte_phase;
    drop_first_next    = drop_first;
    assembly_next      = assembly;
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    selected_next      = selected;
    emit               = 1'b0;
    job                = '0;
    job.sel            = selected;
    case (kind)
      KIND_START: begin
        mode_next          = M_RESET;
        edge_count_next    = '0;
        channel_count_next = '0;
        byte_phase_next    = '0;
        drop_first_next    = 1'b0;
        assembly_next      = '0;
        selected_next      = 1'b0;
        emit               = 1'b1;
        job.code           = JOB_START;
        job.sel            = 1'b0;
      end
      KIND_BURST: begin
        case (mode)
          M_RESET: begin
            emit      = 1'b1;
            job.code  = JOB_CONF;
            mode_next = M_CONF;
          end
          M_CONF: begin
            emit      = 1'b1;
            job.code  = JOB_INSTANT;
            mode_next = M_INSTANT;
          end
          M_INSTANT: begin
            emit      = 1'b1;
            job.code  = JOB_RATE;
            mode_next = M_RATE;
          end
          M_RATE, M_DATA: begin
            emit      = 1'b1;
            job.code  = JOB_DATA;
            mode_next = M_DATA;
          end
          default: begin
          end
        endcase
      end
      KIND_RX: begin
        if (mode == M_STREAM && selected && channel_count < CH_TOTAL) begin
          if (drop_first) begin
            drop_first_next = 1'b0;
          end else begin
            assembly_next = {assembly[SAMPLE_W-BYTE_W-1:0], rx_byte};
            if (byte_phase == 2'd2) begin
              byte_phase_next    = '0;
              channel_count_next = channel_count + 1'b1;
              emit               = 1'b1;
              job.code           = JOB_SAMPLE;
              job.sample         = assembly_next;
              job.channel        = channel_count[CH_W-1:0];
              job.slot           = write_slot;
              // Close the frame once every channel is in
              if (channel_count == CH_LAST) begin
                job.code      = JOB_FRAME;
                selected_next = 1'b0;
                if (wr_adv != read_slot) begin
                  write_slot_next = wr_adv;
                end else begin
                  job.ovf = 1'b1;
                end
              end
            end else begin
              byte_phase_next = byte_phase + 1'b1;
            end
          end
        end
      end
      KIND_EDGE: begin
        edge_count_next = edge_count + 1'b1;
        if (mode == M_STREAM || edge_count == edges_before_stream) begin
          mode_next          = M_STREAM;
          selected_next      = 1'b1;
          channel_count_next = '0;
          byte_phase_next    = '0;
          drop_first_next    = 1'b1;
          assembly_next      = '0;
          emit               = 1'b1;
          job.code           = JOB_STREAM;
          job.sel            = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (read_slot != write_slot) begin
          read_slot_next = rd_adv;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      edge_count    <= '0;
      channel_count <= '0;
      byte_phase    <= '0;
      drop_first    <= 1'b0;
      assembly      <= '0;
      write_slot    <= '0;
      read_slot     <= '0;
      selected      <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      edge_count    <= edge_count_next;
      channel_count <= channel_count_next;
      byte_phase    <= byte_phase_next;
      drop_first    <= drop_first_next;
      assembly      <= assembly_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
      selected      <= selected_next;
    end
  end

  a_slots_in_ring: assert property (@(posedge clk) disable iff (rst)
    (write_slot <= SLOT_LAST) && (read_slot <= SLOT_LAST))
    else $error("ring slot out of range");

  a_select_in_stream: assert property (@(posedge clk) disable iff (rst)
    selected |-> (mode == M_STREAM)) else $error("chip selected outside streaming");

endmodule

@@ sv/safs_back.sv @@
// ----------------------------------------------------------------------------
// safs_back
// Expands queued jobs into result items, one per cycle while the output
// register is free or popped via the empty/pop handshake.
// ----------------------------------------------------------------------------
module safs_back import safs_pkg::*; #(
  parameter int ADC_COUNT = DEF_ADC_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  job_t                       head,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  cfg_t                       cfg,
  output logic                       empty,
  input  logic                       pop,
  output logic [OKIND_W-1:0]         out_kind,
  output logic [BYTE_W-1:0]          tx_byte,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [CH_W-1:0]            channel,
  output logic [SLOT_W-1:0]          slot,
  output logic                       chip_select,
  output logic                       overflow,
  output logic                       last
);

  logic              out_valid;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  len;
  logic              step;
  logic              at_last;
  logic [OKIND_W-1:0] kind_next;
  logic [BYTE_W-1:0] byte_next;
  logic              sel_next;
  logic              ovf_next;
  logic [SAMPLE_W-1:0] sample_next;
  logic [CH_W-1:0]   channel_next;
  logic [SLOT_W-1:0] slot_next;

  assign empty   = !out_valid;
  assign len     = job_len(head.code, ADC_COUNT);
  assign at_last = (idx == len - 1'b1);
  assign step    = !q_empty && (!out_valid || pop);
  assign q_pop   = step && at_last;

  // Pick the result for the current position in the job
  always_comb begin
    kind_next    = OUT_TX;
    byte_next    = '0;
    sel_next     = head.sel;
    ovf_next     = 1'b0;
    sample_next  = '0;
    channel_next = '0;
    slot_next    = '0;
    case (head.code)
      JOB_START:   byte_next = (idx == '0) ? CMD_WR_CONF : ADC_RESET_BYTE;
      JOB_CONF: begin
        if (idx == '0) begin
          byte_next = CMD_WR_CONF;
        end else if (idx == IDX_W'(1)) begin
          byte_next = cfg.first_conf;
        end else begin
          byte_next = cfg.other_conf;
        end
      end
      JOB_INSTANT: byte_next = (idx == '0) ? CMD_WR_INSTANT : '0;
      JOB_RATE: begin
        if (idx == '0) begin
          byte_next = CMD_WR_RATE;
        end else if (idx == IDX_W'(1)) begin
          byte_next = cfg.rate_word[RATE_W-1:BYTE_W];
        end else begin
          byte_next = cfg.rate_word[BYTE_W-1:0];
        end
      end
      JOB_DATA, JOB_STREAM: byte_next = (idx == '0) ? CMD_RD_DATA : '0;
      JOB_SAMPLE, JOB_FRAME: begin
        slot_next = head.slot;
        if (idx == '0) begin
          kind_next    = OUT_SAMPLE;
          sample_next  = head.sample;
          channel_next = head.channel;
        end else begin
          // Frame done: chip released
          kind_next = OUT_FRAME;
          sel_next  = 1'b0;
          ovf_next  = head.ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the payload of the waiting result
  always_ff @(posedge clk) begin
    if (step) begin
      out_kind    <= kind_next;
      tx_byte     <= byte_next;
      sample      <= sample_next;
      channel     <= channel_next;
      slot        <= slot_next;
      chip_select <= sel_next;
      overflow    <= ovf_next;
      last        <= at_last;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (idx < len)) else $error("job position beyond job length");

  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (idx == '0)) else $error("job position left over with no job");

endmodule

@@ sv/spi_adc_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// spi_adc_frame_sequencer
// Frame sequencer for a daisy chain of simultaneous-sampling SPI converters.
// ----------------------------------------------------------------------------
// The block takes one event per cycle (start, burst done, received byte,
// data-ready edge, slot release) as long as full is low; the front end updates
// the sequencer state in that same cycle and queues a job for every event that
// produces output. The back end expands each job into result items, one per
// cycle while pop drains the output register; an event yields 1 + ADC_COUNT
// for start or configuration, 1 + 4*ADC_COUNT for sampling instants, 3 for the
// data rate, 1 + 12*ADC_COUNT for a trial read (49 at ADC_COUNT = 4), 7 for a
// streaming read, 1 or 2 for a received byte that completes a sample and 0 for
// others. Each job passes the job queue and then the output register; the
// queue holds four jobs, so events keep flowing while a long burst drains.
// ----------------------------------------------------------------------------
module spi_adc_frame_sequencer import safs_pkg::*; #(
  parameter int ADC_COUNT     = DEF_ADC_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int RING_SLOTS    = DEF_RING_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [KIND_W-1:0]          kind,
  input  logic [BYTE_W-1:0]          rx_byte,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  output logic                       empty,
  input  logic                       pop,
  output logic [OKIND_W-1:0]         out_kind,
  output logic [BYTE_W-1:0]          tx_byte,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [CH_W-1:0]            channel,
  output logic [SLOT_W-1:0]          slot,
  output logic                       chip_select,
  output logic                       overflow,
  output logic                       last
);

  logic job_valid;
  job_t job_in;
  job_t job_head;
  cfg_t cfg;
  logic q_empty;
  logic q_pop;

  // Accept and classify events
  safs_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .RING_SLOTS   (RING_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .kind     (kind),
    .rx_byte  (rx_byte),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (full),
    .job_valid(job_valid),
    .job      (job_in),
    .cfg      (cfg)
  );

  // Decouple the front end from the result stream
  safs_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_data(job_in),
    .rd_en  (q_pop),
    .rd_data(job_head),
    .empty  (q_empty),
    .full   (full)
  );

  // Expand jobs into results
  safs_back #(
    .ADC_COUNT(ADC_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (job_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .sample     (sample),
    .channel    (channel),
    .slot       (slot),
    .chip_select(chip_select),
    .overflow   (overflow),
    .last       (last)
  );

endmodule
